// ----- hw/rtl/dq_pkg.sv -----
package dq_pkg;

   localparam int DEPTH = 16;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam int IDX_W = $clog2(DEPTH);

   typedef enum logic [2:0] {
      CMD_PUSH_FRONT = 3'd0,
      CMD_PUSH_BACK  = 3'd1,
      CMD_POP_FRONT  = 3'd2,
      CMD_POP_BACK   = 3'd3,
      CMD_DUMP       = 3'd4
   } cmd_type;

   typedef enum logic [1:0] {
      STAT_OK    = 2'd0,
      STAT_EMPTY = 2'd1,
      STAT_FULL  = 2'd2
   } stat_type;

   // what every cell does in a cycle
   typedef enum logic [2:0] {
      OP_HOLD,
      OP_SHR,
      OP_SHL,
      OP_PUT,
      OP_ROT
   } op_type;

   typedef enum logic {
      ST_IDLE,
      ST_DUMP
   } state_type;

   typedef struct packed {
      logic        [2:0]  cmd;
      logic signed [31:0] value;
   } req_type;

   typedef struct packed {
      logic signed [31:0] data;
      logic        [1:0]  status;
      logic [CNT_W-1:0]   occupancy;
      logic               last;
   } rsp_type;

   typedef struct packed {
      op_type             op;
      logic [CNT_W-1:0]   count;
      logic signed [31:0] value;
   } cell_ctl_type;

endpackage

// ----- hw/rtl/dq_cell.sv -----
module dq_cell
   import dq_pkg::*;
(
   input  logic               clock,
   input  logic [IDX_W-1:0]   idx,
   input  cell_ctl_type       ctl,
   input  logic signed [31:0] left_data,
   input  logic signed [31:0] right_data,
   input  logic signed [31:0] head_data,
   output logic signed [31:0] data,
   output logic signed [31:0] tail_data
);

   logic signed [31:0] data_ff;
   logic signed [31:0] data_in;
   logic [CNT_W-1:0]   pos;
   logic               is_tail;
   logic               is_next;
   logic               below_tail;

   assign pos        = CNT_W'(idx);
   assign is_tail    = (ctl.count != '0) && (pos == ctl.count - CNT_W'(1));
   assign is_next    = (pos == ctl.count);
   assign below_tail = (pos + CNT_W'(1) < ctl.count);

   always_comb begin
      data_in = data_ff;
      case (ctl.op)
         OP_SHR: data_in = left_data;
         OP_SHL: data_in = right_data;
         OP_PUT: if (is_next) data_in = ctl.value;
         OP_ROT: begin
            // tail takes the old head, the cells below it move one place toward the front
            if (below_tail) data_in = right_data;
            else if (is_tail) data_in = head_data;
         end
         default: data_in = data_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign data      = data_ff;
   assign tail_data = is_tail ? data_ff : '0;

endmodule

// ----- hw/rtl/double_ended_queue.sv -----
// Double-ended queue of up to DEPTH signed 32-bit values, held in a row of
// cells with the front in cell 0. Each req_ beat carries a command: push front,
// push back, pop front, pop back or dump; every command but a non-empty dump
// returns exactly one rsp_ beat with last set. Pushes and pops are taken one
// per cycle while rsp_ready stays high. A dump of N entries returns N beats,
// front to back, and holds req_ready low until the remaining N-1 beats have
// been accepted, since the row rotates one place per beat through cell 0 and
// is back in order after the last one. A push into a full queue is dropped
// with status full; a pop or dump of an empty queue reports status empty.
// Undefined command codes return status ok and change nothing. The rsp_
// register takes a new beat in the same cycle that the waiting one is
// accepted, so outside a dump, while a result is held, req_ready follows rsp_ready.
module double_ended_queue
   import dq_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data
);

   state_type          state_ff, state_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic [CNT_W-1:0]   dump_left_ff, dump_left_in;
   logic               rsp_valid_ff, rsp_valid_in;
   rsp_type            rsp_data_ff, rsp_data_in;
   cell_ctl_type       ctl;
   logic               slot_free;
   logic               full;
   logic               empty;
   logic signed [31:0] cell_data [DEPTH];
   logic signed [31:0] cell_tail [DEPTH];
   logic signed [31:0] tail_sel;

   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      logic signed [31:0] left_src;
      logic signed [31:0] right_src;
      if (i == 0) begin : g_first
         assign left_src = req_data.value;
      end else begin : g_mid
         assign left_src = cell_data[i-1];
      end
      if (i == DEPTH - 1) begin : g_last
         assign right_src = cell_data[0];
      end else begin : g_inner
         assign right_src = cell_data[i+1];
      end
      dq_cell u_cell (
         .clock      (clock),
         .idx        (IDX_W'(i)),
         .ctl        (ctl),
         .left_data  (left_src),
         .right_data (right_src),
         .head_data  (cell_data[0]),
         .data       (cell_data[i]),
         .tail_data  (cell_tail[i])
      );
   end

   always_comb begin
      tail_sel = '0;
      for (int i = 0; i < DEPTH; i++) begin
         tail_sel = tail_sel | cell_tail[i];
      end
   end

   assign slot_free = !rsp_valid_ff || rsp_ready;
   assign full      = (count_ff >= CNT_W'(DEPTH));
   assign empty     = (count_ff == '0);

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      dump_left_in = dump_left_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_data_in  = rsp_data_ff;
      req_ready    = 1'b0;
      ctl.op       = OP_HOLD;
      ctl.count    = count_ff;
      ctl.value    = req_data.value;
      case (state_ff)
         ST_IDLE: begin
            req_ready = slot_free;
            if (req_valid && slot_free) begin
               rsp_valid_in          = 1'b1;
               rsp_data_in.data      = '0;
               rsp_data_in.status    = STAT_OK;
               rsp_data_in.occupancy = count_ff;
               rsp_data_in.last      = 1'b1;
               case (cmd_type'(req_data.cmd))
                  CMD_PUSH_FRONT, CMD_PUSH_BACK: begin
                     if (full) begin
                        rsp_data_in.status = STAT_FULL;
                     end else begin
                        ctl.op = (cmd_type'(req_data.cmd) == CMD_PUSH_FRONT) ? OP_SHR
                                                                             : OP_PUT;
                        count_in              = count_ff + CNT_W'(1);
                        rsp_data_in.occupancy = count_ff + CNT_W'(1);
                     end
                  end
                  CMD_POP_FRONT, CMD_POP_BACK: begin
                     if (empty) begin
                        rsp_data_in.status = STAT_EMPTY;
                     end else begin
                        if (cmd_type'(req_data.cmd) == CMD_POP_FRONT) begin
                           ctl.op           = OP_SHL;
                           rsp_data_in.data = cell_data[0];
                        end else begin
                           rsp_data_in.data = tail_sel;
                        end
                        count_in              = count_ff - CNT_W'(1);
                        rsp_data_in.occupancy = count_ff - CNT_W'(1);
                     end
                  end
                  CMD_DUMP: begin
                     if (empty) begin
                        rsp_data_in.status = STAT_EMPTY;
                     end else begin
                        ctl.op           = OP_ROT;
                        rsp_data_in.data = cell_data[0];
                        rsp_data_in.last = (count_ff == CNT_W'(1));
                        if (count_ff != CNT_W'(1)) begin
                           state_in     = ST_DUMP;
                           dump_left_in = count_ff - CNT_W'(1);
                        end
                     end
                  end
                  default: ;
               endcase
            end
         end
         ST_DUMP: begin
            if (slot_free) begin
               // advance one entry per beat through the head cell
               ctl.op                = OP_ROT;
               rsp_valid_in          = 1'b1;
               rsp_data_in.data      = cell_data[0];
               rsp_data_in.status    = STAT_OK;
               rsp_data_in.occupancy = count_ff;
               rsp_data_in.last      = (dump_left_ff == CNT_W'(1));
               dump_left_in          = dump_left_ff - CNT_W'(1);
               if (dump_left_ff == CNT_W'(1)) state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         dump_left_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         dump_left_ff <= dump_left_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

`ifndef SYNTH
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(DEPTH))
      else $error("queue count beyond depth");

   a_dump_blocks_req: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DUMP) |-> !req_ready)
      else $error("request taken during dump");

   a_dump_left_live: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DUMP) |-> (dump_left_ff != '0 && dump_left_ff < count_ff))
      else $error("dump counter out of range");

   a_count_step: assert property (@(posedge clock) disable iff (reset)
      !$past(reset) |-> (count_ff == $past(count_ff)
                         || count_ff == $past(count_ff) + CNT_W'(1)
                         || count_ff == $past(count_ff) - CNT_W'(1)))
      else $error("count moved by more than one");

   a_dump_keeps_count: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DUMP) |=> (count_ff == $past(count_ff)))
      else $error("count changed during dump");
`endif

endmodule
